// File: hdl/lmlt_pkg.sv
// shared types, constants and helpers for the lcd mode and line timer
`timescale 1ns / 1ps
`default_nettype none
package lmlt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_DISP_ON      = 2'd0,
    CFG_COMPARE_LINE = 2'd1,
    CFG_STAT_ENABLES = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_W     = 8;
  localparam int MODE_ELAPSED_W = 13;

  localparam logic [7:0] LAST_LINE    = 8'd153;
  localparam logic [7:0] VBLANK_LINE  = 8'd144;
  localparam logic [7:0] LAST_VISIBLE = 8'd143;

  // stat enable bit positions
  localparam int STAT_EN_HBLANK = 0;
  localparam int STAT_EN_VBLANK = 1;
  localparam int STAT_EN_OAM    = 2;
  localparam int STAT_EN_COIN   = 3;

  typedef struct packed {
    mode_t mode;
    logic  stat_req;
  } mode_evt_t;

  typedef struct packed {
    logic [7:0] line;
    logic       coincidence;
    logic       stat_req;
    logic       vblank_irq;
    logic       render_valid;
    logic [7:0] rendered_line;
    logic       frame_start;
  } line_evt_t;

  function automatic logic [MODE_ELAPSED_W-1:0] period_len(input mode_t m);
    logic [MODE_ELAPSED_W-1:0] len;
    case (m)
      MODE_HBLANK: len = 13'd204;
      MODE_VBLANK: len = 13'd4560;
      MODE_OAM:    len = 13'd80;
      MODE_DRAW:   len = 13'd172;
      default:     len = 13'd80;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hdl/lmlt_if.sv
// request channel interfaces for the lcd mode and line timer
`timescale 1ns / 1ps
`default_nettype none
interface lmlt_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink (input valid, input cycles, output ready);
endinterface

interface lmlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic       coincidence;
  logic       stat_irq;
  logic       vblank_irq;
  logic       render_valid;
  logic [7:0] rendered_line;
  logic       frame_start;

  modport source (output valid, output mode, output line, output coincidence,
                  output stat_irq, output vblank_irq, output render_valid,
                  output rendered_line, output frame_start, input ready);
  modport sink (input valid, input mode, input line, input coincidence,
                input stat_irq, input vblank_irq, input render_valid,
                input rendered_line, input frame_start, output ready);
endinterface
`default_nettype wire

// File: hdl/lcd_mode_and_line_timer_unit.sv
// top level of the lcd mode and line timer: request registers and counters
`timescale 1ns / 1ps
`default_nettype none
//
// channel    | dir | fields
// -----------+-----+----------------------------------------------------------
// in_chan    | in  | cycles[5:0]
// out_chan   | out | mode, line, coincidence, stat_irq, vblank_irq,
//            |     | render_valid, rendered_line, frame_start
// cfg_*      | in  | cfg_we, cfg_index[1:0], cfg_wdata[7:0]
//
// one request per clock sustained while out_chan does not stall; an accepted
// request is loaded into the input register, then the counter update loads the
// result register, which offers the result on out_chan
// the counters compute their next state combinationally, so back-to-back requests chain directly
// a stall at out_chan holds the result register and then the input register;
// in_chan is ready while the input register is empty or can move on
// synchronous active-low reset puts mode in oam search, counters to zero
//
module lcd_mode_and_line_timer_unit #(
  parameter int LINE_CYCLES = 456,
  parameter int MAX_STEP    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  lmlt_in_if.sink                                in_chan,
  lmlt_out_if.source                             out_chan,
  input  logic                                   cfg_we,
  input  lmlt_pkg::cfg_idx_t                     cfg_index,
  input  logic [lmlt_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import lmlt_pkg::*;

  // step width holds MAX_STEP itself; line surplus stays below period + step
  localparam int STEP_W = $clog2(MAX_STEP + 1);
  localparam int LE_W   = $clog2(LINE_CYCLES + MAX_STEP);

  // configuration registers
  logic       disp_on_r;
  logic [7:0] compare_line_r;
  logic [3:0] stat_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_on_r      <= 1'b0;
      compare_line_r <= '0;
      stat_en_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISP_ON:      disp_on_r      <= cfg_wdata[0];
        CFG_COMPARE_LINE: compare_line_r <= cfg_wdata[7:0];
        CFG_STAT_ENABLES: stat_en_r      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic              s1_valid_r, s1_valid_nxt;
  logic [STEP_W-1:0] s1_cyc_r;
  logic [STEP_W-1:0] cyc_sat;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;
  logic              in_take;
  logic              proc;

  assign advance = !out_valid_r || out_chan.ready;
  assign proc    = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_take = in_chan.valid && in_chan.ready;

  // oversized steps clip to MAX_STEP before they are registered
  assign cyc_sat = ({26'd0, in_chan.cycles} > 32'(MAX_STEP)) ?
                   STEP_W'(MAX_STEP) : STEP_W'(in_chan.cycles);

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cyc_r <= cyc_sat;
    end
  end

  // counters: mode check sees the line from before this request's line step
  mode_evt_t  mode_evt;
  line_evt_t  line_evt;
  logic [7:0] line_cur;

  lmlt_mode_ctr #(
    .STEP_W (STEP_W)
  ) u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (proc),
    .step_cyc (s1_cyc_r),
    .line_cur (line_cur),
    .stat_en  (stat_en_r),
    .mode_evt (mode_evt)
  );

  lmlt_line_ctr #(
    .LINE_CYCLES (LINE_CYCLES),
    .STEP_W      (STEP_W),
    .LE_W        (LE_W)
  ) u_line (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (proc),
    .step_cyc     (s1_cyc_r),
    .disp_on      (disp_on_r),
    .compare_line (compare_line_r),
    .coin_irq_en  (stat_en_r[STAT_EN_COIN]),
    .line_cur     (line_cur),
    .line_evt     (line_evt)
  );

  // result register
  mode_t     res_mode_r;
  line_evt_t res_line_r;
  logic      res_stat_r;

  always_ff @(posedge clk) begin
    if (proc) begin
      res_mode_r <= mode_evt.mode;
      res_line_r <= line_evt;
      res_stat_r <= mode_evt.stat_req | line_evt.stat_req;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.mode          = res_mode_r;
  assign out_chan.line          = res_line_r.line;
  assign out_chan.coincidence   = res_line_r.coincidence;
  assign out_chan.stat_irq      = res_stat_r;
  assign out_chan.vblank_irq    = res_line_r.vblank_irq;
  assign out_chan.render_valid  = res_line_r.render_valid;
  assign out_chan.rendered_line = res_line_r.rendered_line;
  assign out_chan.frame_start   = res_line_r.frame_start;

  // a waiting request is held, not dropped, while the result side stalls
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_cyc_r))
    else $error("input request lost during stall");

  a_wrap_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_line_r.frame_start &&
                      (res_line_r.vblank_irq || res_line_r.render_valid)))
    else $error("frame start together with a line step event");

  a_render_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_line_r.render_valid |-> res_line_r.rendered_line < VBLANK_LINE)
    else $error("render of a non-visible line");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_line_r.vblank_irq |-> res_line_r.line == VBLANK_LINE)
    else $error("vblank request off the vblank line");

endmodule
`default_nettype wire

// File: hdl/lmlt_mode_ctr.sv
// display mode period counter and mode sequencer
`timescale 1ns / 1ps
`default_nettype none
module lmlt_mode_ctr #(
  parameter int STEP_W = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [STEP_W-1:0]      step_cyc,
  input  logic [7:0]             line_cur,
  input  logic [3:0]             stat_en,
  output lmlt_pkg::mode_evt_t    mode_evt
);
  import lmlt_pkg::*;

  mode_t                     mode_r, mode_nxt;
  logic [MODE_ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [MODE_ELAPSED_W-1:0] sum;
  logic [MODE_ELAPSED_W-1:0] len;
  logic                      stat_req;

  always_comb begin
    sum         = elapsed_r + MODE_ELAPSED_W'(step_cyc);
    len         = period_len(mode_r);
    mode_nxt    = mode_r;
    elapsed_nxt = sum;
    stat_req    = 1'b0;
    if (sum >= len) begin
      elapsed_nxt = sum - len;
      case (mode_r)
        MODE_OAM: begin
          mode_nxt = MODE_DRAW;
        end
        MODE_DRAW: begin
          mode_nxt = MODE_HBLANK;
          stat_req = stat_en[STAT_EN_HBLANK];
        end
        MODE_HBLANK: begin
          if (line_cur == LAST_VISIBLE) begin
            mode_nxt = MODE_VBLANK;
            stat_req = stat_en[STAT_EN_VBLANK];
          end else begin
            mode_nxt = MODE_OAM;
            stat_req = stat_en[STAT_EN_OAM];
          end
        end
        default: begin
          mode_nxt = MODE_OAM;
          stat_req = stat_en[STAT_EN_OAM];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OAM;
      elapsed_r <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign mode_evt.mode     = mode_nxt;
  assign mode_evt.stat_req = stat_req;

  // carried surplus always stays below the current period
  a_elapsed_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r < period_len(mode_r))
    else $error("mode elapsed count beyond its period");

endmodule
`default_nettype wire

// File: hdl/lmlt_line_ctr.sv
// line period counter, line register and coincidence compare
`timescale 1ns / 1ps
`default_nettype none
module lmlt_line_ctr #(
  parameter int LINE_CYCLES = 456,
  parameter int STEP_W      = 6,
  parameter int LE_W        = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [STEP_W-1:0]   step_cyc,
  input  logic                disp_on,
  input  logic [7:0]          compare_line,
  input  logic                coin_irq_en,
  output logic [7:0]          line_cur,
  output lmlt_pkg::line_evt_t line_evt
);
  import lmlt_pkg::*;

  logic [LE_W-1:0] elapsed_r, elapsed_nxt;
  logic [LE_W-1:0] sum;
  logic [7:0]      line_r, line_nxt;
  logic            coin_r, coin_nxt;
  logic            stat_req, vblank_irq, render_valid, frame_start;
  logic [7:0]      rendered_line;

  always_comb begin
    sum           = elapsed_r + LE_W'(step_cyc);
    elapsed_nxt   = sum;
    line_nxt      = line_r;
    coin_nxt      = coin_r;
    stat_req      = 1'b0;
    vblank_irq    = 1'b0;
    render_valid  = 1'b0;
    rendered_line = '0;
    frame_start   = 1'b0;
    if (sum >= LE_W'(LINE_CYCLES)) begin
      elapsed_nxt = sum - LE_W'(LINE_CYCLES);
      if (disp_on) begin
        if (line_r == LAST_LINE) begin
          line_nxt    = '0;
          frame_start = 1'b1;
        end else begin
          if (line_r < VBLANK_LINE) begin
            render_valid  = 1'b1;
            rendered_line = line_r;
          end
          coin_nxt   = (line_r == compare_line);
          stat_req   = coin_nxt & coin_irq_en;
          line_nxt   = line_r + 8'd1;
          vblank_irq = (line_nxt == VBLANK_LINE);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      line_r    <= '0;
      coin_r    <= 1'b0;
    end else if (step_en) begin
      elapsed_r <= elapsed_nxt;
      line_r    <= line_nxt;
      coin_r    <= coin_nxt;
    end
  end

  assign line_cur                = line_r;
  assign line_evt.line           = line_nxt;
  assign line_evt.coincidence    = coin_nxt;
  assign line_evt.stat_req       = stat_req;
  assign line_evt.vblank_irq     = vblank_irq;
  assign line_evt.render_valid   = render_valid;
  assign line_evt.rendered_line  = rendered_line;
  assign line_evt.frame_start    = frame_start;

  a_elapsed_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r < LE_W'(LINE_CYCLES))
    else $error("line elapsed count beyond line period");

  a_line_frozen_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    !disp_on |=> $stable(line_r) && $stable(coin_r))
    else $error("line moved while display disabled");

endmodule
`default_nettype wire

// File: sim/lmlt_timing_checker.sv
// checker for the lcd mode and line timer: predicts each result and compares it
`timescale 1ns / 1ps
module lmlt_timing_checker #(
  parameter int LINE_CYCLES = 456,
  parameter int MAX_STEP    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  lmlt_in_if                  in_mon,
  lmlt_out_if                 out_mon,
  input  logic                cfg_we,
  input  lmlt_pkg::cfg_idx_t  cfg_index,
  input  logic [7:0]          cfg_wdata,
  output int unsigned         outstanding,
  output int unsigned         mismatch_count
);
  import lmlt_pkg::*;

  localparam logic [12:0] HBLANK_LEN = 13'd204;
  localparam logic [12:0] VBLANK_LEN = 13'd4560;
  localparam logic [12:0] OAM_LEN    = 13'd80;
  localparam logic [12:0] DRAW_LEN   = 13'd172;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       render_valid;
    logic [7:0] rendered_line;
    logic       frame_start;
  } timing_result_t;

  // register copies
  logic       lcd_on;
  logic [7:0] lyc;
  logic [3:0] irq_en;

  // timer state
  mode_t       cur_mode;
  logic [12:0] mode_cnt;
  logic [9:0]  line_cnt;
  logic [7:0]  cur_line;
  logic        coin_flag;

  timing_result_t expected_q[$];
  timing_result_t want;
  timing_result_t got;
  int unsigned    errs = 0;

  function automatic timing_result_t advance_timer(input logic [5:0] raw);
    timing_result_t res;
    int unsigned    step;
    logic [12:0]    len;
    res  = '0;
    step = (raw > MAX_STEP) ? MAX_STEP : raw;

    // mode period first, against the line from before this request
    mode_cnt = mode_cnt + 13'(step);
    case (cur_mode)
      MODE_HBLANK: len = HBLANK_LEN;
      MODE_VBLANK: len = VBLANK_LEN;
      MODE_OAM:    len = OAM_LEN;
      default:     len = DRAW_LEN;
    endcase
    if (mode_cnt >= len) begin
      mode_cnt = mode_cnt - len;
      case (cur_mode)
        MODE_OAM: cur_mode = MODE_DRAW;
        MODE_DRAW: begin
          cur_mode = MODE_HBLANK;
          if (irq_en[STAT_EN_HBLANK]) res.stat_irq = 1'b1;
        end
        MODE_HBLANK: begin
          if (cur_line == LAST_VISIBLE) begin
            cur_mode = MODE_VBLANK;
            if (irq_en[STAT_EN_VBLANK]) res.stat_irq = 1'b1;
          end else begin
            cur_mode = MODE_OAM;
            if (irq_en[STAT_EN_OAM]) res.stat_irq = 1'b1;
          end
        end
        default: begin
          cur_mode = MODE_OAM;
          if (irq_en[STAT_EN_OAM]) res.stat_irq = 1'b1;
        end
      endcase
    end

    // line period runs even when the lcd is off, only the line holds
    line_cnt = line_cnt + 10'(step);
    if (line_cnt >= LINE_CYCLES) begin
      line_cnt = line_cnt - 10'(LINE_CYCLES);
      if (lcd_on) begin
        if (cur_line == LAST_LINE) begin
          cur_line        = '0;
          res.frame_start = 1'b1;
        end else begin
          if (cur_line < VBLANK_LINE) begin
            res.render_valid  = 1'b1;
            res.rendered_line = cur_line;
          end
          coin_flag = (cur_line == lyc);
          if (coin_flag && irq_en[STAT_EN_COIN]) res.stat_irq = 1'b1;
          cur_line = cur_line + 8'd1;
          if (cur_line == VBLANK_LINE) res.vblank_irq = 1'b1;
        end
      end
    end

    res.mode        = cur_mode;
    res.line        = cur_line;
    res.coincidence = coin_flag;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lcd_on    = 1'b0;
      lyc       = '0;
      irq_en    = '0;
      cur_mode  = MODE_OAM;
      mode_cnt  = '0;
      line_cnt  = '0;
      cur_line  = '0;
      coin_flag = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISP_ON:      lcd_on = cfg_wdata[0];
          CFG_COMPARE_LINE: lyc    = cfg_wdata;
          CFG_STAT_ENABLES: irq_en = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.mode          = mode_t'(out_mon.mode);
        got.line          = out_mon.line;
        got.coincidence   = out_mon.coincidence;
        got.stat_irq      = out_mon.stat_irq;
        got.vblank_irq    = out_mon.vblank_irq;
        got.render_valid  = out_mon.render_valid;
        got.rendered_line = out_mon.rendered_line;
        got.frame_start   = out_mon.frame_start;
        if (expected_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t unexpected result: mode %0d line %0d", $realtime, got.mode,
                     got.line);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t mismatch  mode line coin stat vbl rnd rline frame", $realtime);
              $display("  expected  %0d %0d %0b %0b %0b %0b %0d %0b", want.mode, want.line,
                       want.coincidence, want.stat_irq, want.vblank_irq, want.render_valid,
                       want.rendered_line, want.frame_start);
              $display("  actual    %0d %0d %0b %0b %0b %0b %0d %0b", got.mode, got.line,
                       got.coincidence, got.stat_irq, got.vblank_irq, got.render_valid,
                       got.rendered_line, got.frame_start);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(advance_timer(in_mon.cycles));
    end
    outstanding    <= expected_q.size();
    mismatch_count <= errs;
  end

endmodule

// File: sim/lcd_mode_and_line_timer_unit_test.sv
// testbench top for the lcd mode and line timer: stimulus, stalls and verdict
`timescale 1ns / 1ps
module lcd_mode_and_line_timer_unit_test;
  import lmlt_pkg::*;

  localparam int LINE_CYCLES    = 456;
  localparam int MAX_STEP       = 32;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 6;
  // about 1600 requests in all; the line counter carries over from one
  // phase to the next, so the enabled phases walk it through many lines
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 160;
  // pipeline is two deep; the spare drain cycles cover it
  localparam int DRAIN_CYCLES   = 4;
  // worst honest stall is the longest sender gap or ready hole, both far below this limit
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_wdata;

  // receiver stall pattern, rotated one bit per clock
  logic [15:0] ready_pat;
  logic [3:0]  ready_pos = '0;

  int unsigned outstanding;
  int unsigned mismatch_count;
  int unsigned idle_cycles = 0;

  // sender burst shaping
  int unsigned burst_left;
  int unsigned max_gap;

  // directed warm-up with registers at reset (lcd off): zero step, smallest
  // step, saturated steps, alternating bit patterns, then enough cycles for
  // a line period to pass while the line counter is held
  logic [5:0] warmup_steps [18] = '{
    6'd0, 6'd1, 6'd63, 6'd33, 6'd42, 6'd21, 6'd31, 6'd2, 6'd63,
    6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63
  };

  lmlt_in_if  in_chan();
  lmlt_out_if out_chan();

  lcd_mode_and_line_timer_unit #(
    .LINE_CYCLES (LINE_CYCLES),
    .MAX_STEP    (MAX_STEP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lmlt_timing_checker #(
    .LINE_CYCLES (LINE_CYCLES),
    .MAX_STEP    (MAX_STEP)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // result side: ready follows the current stall pattern
  always @(posedge clk) begin
    out_chan.ready <= ready_pat[ready_pos];
    ready_pos      <= ready_pos + 4'd1;
  end

  // watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lcd_mode_and_line_timer_unit verification failed");
      $finish;
    end
  end

  // step sizes lean large so the line counter gets through many lines;
  // zero and saturating steps stay in the mix
  function automatic logic [5:0] pick_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return 6'd0;
    else if (roll < 15)
      return 6'($urandom_range(1, 27));
    else if (roll < 40)
      return 6'($urandom_range(33, 63));
    else
      return 6'($urandom_range(28, 32));
  endfunction

  // present one request and hold it until the block takes it;
  // always entered right after a rising edge
  task automatic send_request(input logic [5:0] step);
    in_chan.valid  <= 1'b1;
    in_chan.cycles <= step;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // bursts of random length with random gaps; noise on cycles while idle
  task automatic issue_request(input logic [5:0] step);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_chan.valid  <= 1'b0;
        in_chan.cycles <= 6'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    send_request(step);
    burst_left--;
  endtask

  // wait until every expected result is back, then let the pipe drain
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic configure(input logic en, input logic [7:0] cmp, input logic [3:0] irqs);
    settle();
    write_reg(CFG_DISP_ON, {7'd0, en});
    write_reg(CFG_COMPARE_LINE, cmp);
    write_reg(CFG_STAT_ENABLES, {4'd0, irqs});
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_chan.valid  <= 1'b0;
    in_chan.cycles <= '0;
    ready_pat      <= '1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_DISP_ON;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    burst_left     = 0;
    max_gap        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, back to back with the receiver always ready
    foreach (warmup_steps[i]) send_request(warmup_steps[i]);
    in_chan.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // extremes first, lcd off at the end, random settings in between
      if (p == 0)
        configure(1'b1, 8'd0, 4'hf);
      else if (p == 1)
        configure(1'b1, 8'd255, 4'h0);
      else if (p == PHASES - 1)
        configure(1'b0, 8'($urandom_range(0, 255)), 4'hf);
      else
        configure(1'b1, 8'($urandom_range(0, 153)), 4'($urandom_range(0, 15)));

      // every third phase runs flat out on both sides
      if (p % 3 == 0) begin
        max_gap = 0;
        ready_pat <= '1;
      end else begin
        max_gap = $urandom_range(1, 8);
        ready_pat <= 16'($urandom) | 16'h0001;
      end
      burst_left = 0;

      repeat (PHASE_REQUESTS) issue_request(pick_cycles());
      in_chan.valid <= 1'b0;
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0)
      $display("lcd_mode_and_line_timer_unit verification clean");
    else
      $display("lcd_mode_and_line_timer_unit verification failed");
    $finish;
  end

endmodule
